### hdl/qrv_pkg.sv
`default_nettype none

package qrv_pkg;

	// Quaternion component width, signed Q2.14.
	localparam int QW = 16;
	// Default vector component width.
	localparam int VEC_WIDTH_DEF = 24;
	// Product of two quaternion components.
	localparam int PROD_W = 2 * QW;
	// Rotation matrix entry, scaled by 2^FRAC. Magnitude stays within 2^32 + 2^28.
	localparam int MAT_W = 35;
	// Fraction bits of a matrix entry.
	localparam int FRAC = 28;

endpackage

`default_nettype wire

### hdl/qrv_if.sv
`default_nettype none

interface qrv_req_if #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [qrv_pkg::QW-1:0]   q_w;
	logic signed [qrv_pkg::QW-1:0]   q_x;
	logic signed [qrv_pkg::QW-1:0]   q_y;
	logic signed [qrv_pkg::QW-1:0]   q_z;
	logic signed [VEC_WIDTH-1:0]     v_x;
	logic signed [VEC_WIDTH-1:0]     v_y;
	logic signed [VEC_WIDTH-1:0]     v_z;

	modport source (output valid, q_w, q_x, q_y, q_z, v_x, v_y, v_z, input ready);
	modport sink (input valid, q_w, q_x, q_y, q_z, v_x, v_y, v_z, output ready);
endinterface

interface qrv_rsp_if #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [VEC_WIDTH-1:0] r_x;
	logic signed [VEC_WIDTH-1:0] r_y;
	logic signed [VEC_WIDTH-1:0] r_z;
	logic                        saturated;

	modport source (output valid, r_x, r_y, r_z, saturated, input ready);
	modport sink (input valid, r_x, r_y, r_z, saturated, output ready);
endinterface

`default_nettype wire

### hdl/qrv_mat.sv
`default_nettype none

// Two stages: component products, then the scaled rotation matrix.
module qrv_mat #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [qrv_pkg::QW-1:0]         q_w,
	input  logic signed [qrv_pkg::QW-1:0]         q_x,
	input  logic signed [qrv_pkg::QW-1:0]         q_y,
	input  logic signed [qrv_pkg::QW-1:0]         q_z,
	input  logic signed [VEC_WIDTH-1:0]           v_in [3],
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qrv_pkg::MAT_W-1:0]      m_out [3][3],
	output logic signed [VEC_WIDTH-1:0]           v_out [3]
);
	localparam int MW = qrv_pkg::MAT_W;
	localparam int PW = qrv_pkg::PROD_W;
	localparam logic signed [MW-1:0] ONE_M =
		{{(MW - qrv_pkg::FRAC - 1){1'b0}}, 1'b1, {qrv_pkg::FRAC{1'b0}}};

	logic                        valid_s1, valid_s2;
	logic                        en_s1, en_s2;
	logic signed [PW-1:0]        xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [VEC_WIDTH-1:0] v_s1 [3];
	logic signed [MW-1:0]        e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
	logic signed [MW-1:0]        m_d [3][3];
	logic signed [MW-1:0]        m_s2 [3][3];
	logic signed [VEC_WIDTH-1:0] v_s2 [3];

	// A stage takes new data when it is empty or its successor takes its item.
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			xx_s1 <= q_x * q_x;
			yy_s1 <= q_y * q_y;
			zz_s1 <= q_z * q_z;
			xy_s1 <= q_x * q_y;
			xz_s1 <= q_x * q_z;
			yz_s1 <= q_y * q_z;
			wx_s1 <= q_w * q_x;
			wy_s1 <= q_w * q_y;
			wz_s1 <= q_w * q_z;
			v_s1  <= v_in;
		end
	end

	always_comb begin
		e_xx = MW'(xx_s1);
		e_yy = MW'(yy_s1);
		e_zz = MW'(zz_s1);
		e_xy = MW'(xy_s1);
		e_xz = MW'(xz_s1);
		e_yz = MW'(yz_s1);
		e_wx = MW'(wx_s1);
		e_wy = MW'(wy_s1);
		e_wz = MW'(wz_s1);
		m_d[0][0] = ONE_M - ((e_yy + e_zz) <<< 1);
		m_d[0][1] = (e_xy - e_wz) <<< 1;
		m_d[0][2] = (e_xz + e_wy) <<< 1;
		m_d[1][0] = (e_xy + e_wz) <<< 1;
		m_d[1][1] = ONE_M - ((e_xx + e_zz) <<< 1);
		m_d[1][2] = (e_yz - e_wx) <<< 1;
		m_d[2][0] = (e_xz - e_wy) <<< 1;
		m_d[2][1] = (e_yz + e_wx) <<< 1;
		m_d[2][2] = ONE_M - ((e_xx + e_yy) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			m_s2 <= m_d;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = valid_s2;
	assign m_out     = m_s2;
	assign v_out     = v_s2;

endmodule

`default_nettype wire

### hdl/qrv_dot.sv
`default_nettype none

// Two stages: matrix-by-vector products, then row sums rounded to nearest.
module qrv_dot #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [qrv_pkg::MAT_W-1:0]       m_in [3][3],
	input  logic signed [VEC_WIDTH-1:0]            v_in [3],
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [qrv_pkg::MAT_W+VEC_WIDTH+1-qrv_pkg::FRAC:0] rnd_out [3]
);
	localparam int PW = qrv_pkg::MAT_W + VEC_WIDTH;
	localparam int SW = PW + 2;
	localparam int RW = SW - qrv_pkg::FRAC;
	localparam logic signed [SW-1:0] HALF_S =
		{{(SW - qrv_pkg::FRAC){1'b0}}, 1'b1, {(qrv_pkg::FRAC - 1){1'b0}}};

	logic                 valid_s3, valid_s4;
	logic                 en_s3, en_s4;
	logic signed [PW-1:0] prod_s3 [3][3];
	logic signed [SW-1:0] sum_d [3];
	logic signed [RW-1:0] rnd_s4 [3];

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= in_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s3[r][c] <= PW'(m_in[r][c]) * PW'(v_in[c]);
				end
			end
		end
	end

	// Add half, then floor: ties go toward plus infinity.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_d[r] = SW'(prod_s3[r][0]) + SW'(prod_s3[r][1]) + SW'(prod_s3[r][2]) + HALF_S;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			for (int r = 0; r < 3; r++) begin
				rnd_s4[r] <= sum_d[r][SW-1:qrv_pkg::FRAC];
			end
		end
	end

	assign out_valid = valid_s4;
	assign rnd_out   = rnd_s4;

endmodule

`default_nettype wire

### hdl/qrv_sat.sv
`default_nettype none

// Output stage: clip each component to the vector width and flag any clip.
module qrv_sat #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [qrv_pkg::MAT_W+VEC_WIDTH+1-qrv_pkg::FRAC:0] rnd_in [3],
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [VEC_WIDTH-1:0]            r_out [3],
	output logic                                   sat_out
);
	localparam int RW = qrv_pkg::MAT_W + VEC_WIDTH + 2 - qrv_pkg::FRAC;

	logic                        valid_s5;
	logic                        en_s5;
	logic [2:0]                  ovf;
	logic signed [VEC_WIDTH-1:0] clip_d [3];
	logic signed [VEC_WIDTH-1:0] r_s5 [3];
	logic                        sat_s5;

	assign en_s5    = !valid_s5 || out_ready;
	assign in_ready = en_s5;

	// Out of range when the kept sign bit or any bit above it disagrees with the sign.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ovf[k] = (rnd_in[k][RW-1:VEC_WIDTH-1] != {(RW - VEC_WIDTH + 1){rnd_in[k][RW-1]}});
			if (ovf[k]) begin
				clip_d[k] = {rnd_in[k][RW-1], {(VEC_WIDTH - 1){~rnd_in[k][RW-1]}}};
			end else begin
				clip_d[k] = rnd_in[k][VEC_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			r_s5   <= clip_d;
			sat_s5 <= |ovf;
		end
	end

	assign out_valid = valid_s5;
	assign r_out     = r_s5;
	assign sat_out   = sat_s5;

endmodule

`default_nettype wire

### hdl/quaternion_rotate_vector.sv
`default_nettype none

// Channel  Role    Carries
// -------  ------  ---------------------------------------------------------------
// req      sink    quaternion q_w/q_x/q_y/q_z (Q2.14), vector v_x/v_y/v_z
// rsp      source  rotated vector r_x/r_y/r_z, saturated flag
//
// One request enters per clock while no stall on rsp holds the stages full; its response
// passes through the five register stages (products, matrix, nine multipliers, row sums,
// clip), the first of which loads at the accepting edge.
// arst_n clears only the stage valid bits; payload registers are left as they are.
// A stall on rsp holds the full stages in place; empty stages keep filling, so
// req.ready drops only once every stage holds a request.
module quaternion_rotate_vector #(
	parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qrv_req_if.sink    req,
	qrv_rsp_if.source  rsp
);
	localparam int RW = qrv_pkg::MAT_W + VEC_WIDTH + 2 - qrv_pkg::FRAC;

	// Vector components gathered as an array for the row products.
	logic signed [VEC_WIDTH-1:0]         v_req [3];

	// Matrix stage to dot-product stage.
	logic                                mat_valid;
	logic                                mat_ready;
	logic signed [qrv_pkg::MAT_W-1:0]    mat_m [3][3];
	logic signed [VEC_WIDTH-1:0]         mat_v [3];

	// Dot-product stage to clip stage.
	logic                                dot_valid;
	logic                                dot_ready;
	logic signed [RW-1:0]                dot_rnd [3];

	// Clip stage outputs.
	logic signed [VEC_WIDTH-1:0]         sat_r [3];

	assign v_req[0] = req.v_x;
	assign v_req[1] = req.v_y;
	assign v_req[2] = req.v_z;

	// Stages 1-2: quaternion products, then matrix entries scaled by 2^28.
	qrv_mat #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.q_w       (req.q_w),
		.q_x       (req.q_x),
		.q_y       (req.q_y),
		.q_z       (req.q_z),
		.v_in      (v_req),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.m_out     (mat_m),
		.v_out     (mat_v)
	);

	// Stages 3-4: exact row products and sums, round to nearest.
	qrv_dot #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.m_in      (mat_m),
		.v_in      (mat_v),
		.out_valid (dot_valid),
		.out_ready (dot_ready),
		.rnd_out   (dot_rnd)
	);

	// Stage 5: clip to the vector width; this register drives rsp directly.
	qrv_sat #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dot_valid),
		.in_ready  (dot_ready),
		.rnd_in    (dot_rnd),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.r_out     (sat_r),
		.sat_out   (rsp.saturated)
	);

	assign rsp.r_x = sat_r[0];
	assign rsp.r_y = sat_r[1];
	assign rsp.r_z = sat_r[2];

endmodule

`default_nettype wire

### verif/quaternion_rotate_vector_tb.sv
`timescale 1ns / 100ps

module quaternion_rotate_vector_tb;

	localparam int QW         = qrv_pkg::QW;
	localparam int FRAC       = qrv_pkg::FRAC;
	localparam int VW         = qrv_pkg::VEC_WIDTH_DEF;
	localparam int CYCLE_MAX  = 200000;
	localparam int N_RANDOM   = 400;
	localparam int N_DIRECTED = 19;
	localparam int HOLD_LEN   = 64;
	localparam int DRAIN_WAIT = 20;
	localparam longint ONE_FIX  = longint'(1) << FRAC;
	localparam longint HALF_FIX = longint'(1) << (FRAC - 1);
	localparam longint V_MAX    = (longint'(1) << (VW - 1)) - 1;
	localparam longint V_MIN    = -(longint'(1) << (VW - 1));

	typedef struct packed {
		logic signed [QW-1:0] q_w;
		logic signed [QW-1:0] q_x;
		logic signed [QW-1:0] q_y;
		logic signed [QW-1:0] q_z;
		logic signed [VW-1:0] v_x;
		logic signed [VW-1:0] v_y;
		logic signed [VW-1:0] v_z;
	} rot_req_t;

	typedef struct packed {
		logic signed [VW-1:0] r_x;
		logic signed [VW-1:0] r_y;
		logic signed [VW-1:0] r_z;
		logic                 saturated;
	} rot_rsp_t;

	// One directed row: the request, and a literal response where it is obvious.
	typedef struct packed {
		rot_req_t rq;
		logic     fixed_rsp;
		rot_rsp_t rs;
	} dir_row_t;

	logic clk;
	logic arst_n;

	qrv_req_if #(.VEC_WIDTH(VW)) req_ch ();
	qrv_rsp_if #(.VEC_WIDTH(VW)) rsp_ch ();

	quaternion_rotate_vector #(.VEC_WIDTH(VW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Rotated vectors still owed by the block, oldest first.
	rot_rsp_t rotated_pending[$];
	int       n_errors;
	// Set by the stimulus to open a long receiver hold-off.
	logic     hold_req;
	// While set, neither side inserts idle cycles.
	logic     calm;

	// Directed table. Rows with fixed_rsp set carry a response read off by hand:
	// identity and zero quaternions pass the vector through, half turns about an
	// axis negate two components, q_x = 0.5 halves two components with ties
	// going up, q_x = -2.0 scales two components by -7 (and saturates in one row).
	dir_row_t dir_rows[N_DIRECTED] = '{
		'{'{16384, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}},
		'{'{16384, 0, 0, 0, 8388607, -8388608, 1}, 1'b1,
			'{8388607, -8388608, 1, 1'b0}},
		'{'{0, 0, 0, 0, -8388608, 8388607, -1}, 1'b1, '{-8388608, 8388607, -1, 1'b0}},
		'{'{-16384, 0, 0, 0, -8388608, 0, 8388607}, 1'b1, '{-8388608, 0, 8388607, 1'b0}},
		'{'{0, 16384, 0, 0, 123, -8388608, 8388607}, 1'b1,
			'{123, 8388607, -8388607, 1'b1}},
		'{'{0, 0, 16384, 0, 7, 8, 9}, 1'b1, '{-7, 8, -9, 1'b0}},
		'{'{0, 0, 0, 16384, 7, 8, 9}, 1'b1, '{-7, -8, 9, 1'b0}},
		'{'{0, 8192, 0, 0, 5, -1, -3}, 1'b1, '{5, 0, -1, 1'b0}},
		'{'{0, 8192, 0, 0, 0, 1, 3}, 1'b1, '{0, 1, 2, 1'b0}},
		'{'{0, -32768, 0, 0, 0, 1000000, -1000000}, 1'b1, '{0, -7000000, 7000000, 1'b0}},
		'{'{0, -32768, 0, 0, 0, 2000000, 0}, 1'b1, '{0, -8388608, 0, 1'b1}},
		'{'{-32768, -32768, -32768, -32768, 1, 1, 1}, 1'b0, '0},
		'{'{32767, 32767, 32767, 32767, 8388607, 8388607, 8388607}, 1'b0, '0},
		'{'{32767, -32768, 32767, -32768, -8388608, -8388608, -8388608}, 1'b0, '0},
		'{'{11585, 0, 0, 11585, 1000, 0, 0}, 1'b0, '0},
		'{'{11585, 11585, 0, 0, 0, -1000, 4096}, 1'b0, '0},
		'{'{8192, 8192, 8192, 8192, 100, 200, 300}, 1'b0, '0},
		'{'{1, -1, 1, -1, 8388607, 0, -8388608}, 1'b0, '0},
		'{'{21845, -21846, 10922, -10923, 5592405, -5592406, 0}, 1'b0, '0}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Rotate the vector by the quaternion as formed: exact matrix at 2^FRAC,
	// exact row sums, round half up, clip to the vector width.
	function automatic rot_rsp_t rotate_expect(input rot_req_t rq);
		longint w, x, y, z;
		longint vec[3];
		longint mat[3][3];
		longint acc[3];
		rot_rsp_t rs;
		w = longint'(signed'(rq.q_w));
		x = longint'(signed'(rq.q_x));
		y = longint'(signed'(rq.q_y));
		z = longint'(signed'(rq.q_z));
		vec[0] = longint'(signed'(rq.v_x));
		vec[1] = longint'(signed'(rq.v_y));
		vec[2] = longint'(signed'(rq.v_z));
		mat[0][0] = ONE_FIX - 2 * (y * y + z * z);
		mat[0][1] = 2 * (x * y - w * z);
		mat[0][2] = 2 * (x * z + w * y);
		mat[1][0] = 2 * (x * y + w * z);
		mat[1][1] = ONE_FIX - 2 * (x * x + z * z);
		mat[1][2] = 2 * (y * z - w * x);
		mat[2][0] = 2 * (x * z - w * y);
		mat[2][1] = 2 * (y * z + w * x);
		mat[2][2] = ONE_FIX - 2 * (x * x + y * y);
		rs.saturated = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc[i] = HALF_FIX;
			for (int j = 0; j < 3; j++)
				acc[i] += mat[i][j] * vec[j];
			// Arithmetic shift of a signed longint floors, as the rounding needs.
			acc[i] = acc[i] >>> FRAC;
			if (acc[i] > V_MAX) begin
				acc[i] = V_MAX;
				rs.saturated = 1'b1;
			end else if (acc[i] < V_MIN) begin
				acc[i] = V_MIN;
				rs.saturated = 1'b1;
			end
		end
		rs.r_x = acc[0][VW-1:0];
		rs.r_y = acc[1][VW-1:0];
		rs.r_z = acc[2][VW-1:0];
		return rs;
	endfunction

	function automatic logic takes_break();
		return !calm && ($urandom_range(99) < 26);
	endfunction

	// Quaternion component: full range, near-unit range, a unit-ish constant, or small.
	function automatic logic signed [QW-1:0] pick_quat(input int mode);
		logic signed [QW-1:0] c;
		case (mode)
			0:       c = QW'($urandom);
			1:       c = QW'($urandom_range(18918) - 9459);
			2: begin
				case ($urandom_range(4))
					0:       c = 0;
					1:       c = 11585;
					2:       c = -11585;
					3:       c = 8192;
					default: c = -8192;
				endcase
			end
			default: c = QW'($urandom_range(64) - 32);
		endcase
		return c;
	endfunction

	// Vector component: full range or small.
	function automatic logic signed [VW-1:0] pick_vec(input int mode);
		logic signed [VW-1:0] c;
		if (mode == 0)
			c = VW'($urandom);
		else
			c = VW'($urandom_range(2000) - 1000);
		return c;
	endfunction

	// Offer one request, idling at random first; record its response on accept.
	task automatic push_req(input rot_req_t rq, input rot_rsp_t rs);
		while (takes_break()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.q_w   <= rq.q_w;
		req_ch.q_x   <= rq.q_x;
		req_ch.q_y   <= rq.q_y;
		req_ch.q_z   <= rq.q_z;
		req_ch.v_x   <= rq.v_x;
		req_ch.v_y   <= rq.v_y;
		req_ch.v_z   <= rq.v_z;
		do
			@(posedge clk);
		while (!req_ch.ready);
		rotated_pending.push_back(rs);
	endtask

	// Drop valid and hold until every owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (rotated_pending.size() != 0);
	endtask

	// Stimulus: reset, directed table, then random requests.
	initial begin
		rot_req_t rq;
		int qmode;
		int vmode;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.q_w   = '0;
		req_ch.q_x   = '0;
		req_ch.q_y   = '0;
		req_ch.q_z   = '0;
		req_ch.v_x   = '0;
		req_ch.v_y   = '0;
		req_ch.v_z   = '0;
		hold_req     = 1'b0;
		calm         = 1'b0;
		n_errors     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_req(dir_rows[i].rq,
				dir_rows[i].fixed_rsp ? dir_rows[i].rs : rotate_expect(dir_rows[i].rq));

		for (int n = 0; n < N_RANDOM; n++) begin
			// Open a long receiver hold-off; keep offering so the pipe backs up.
			if (n == 120)
				hold_req = 1'b1;
			// Run a stretch at full rate on both sides.
			calm = (n >= 200 && n < 260);
			// Pause the sender until the block has drained completely.
			if (n == 300)
				wait_drained();
			qmode = $urandom_range(9);
			qmode = (qmode < 3) ? 0 : (qmode < 7) ? 1 : (qmode < 9) ? 2 : 3;
			vmode = ($urandom_range(3) == 0) ? 1 : 0;
			rq.q_w = pick_quat(qmode);
			rq.q_x = pick_quat(qmode);
			rq.q_y = pick_quat(qmode);
			rq.q_z = pick_quat(qmode);
			rq.v_x = pick_vec(vmode);
			rq.v_y = pick_vec(vmode);
			rq.v_z = pick_vec(vmode);
			push_req(rq, rotate_expect(rq));
		end
		calm = 1'b0;

		wait_drained();
		// Give a late or extra response time to show up.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Response side: check each accepted response, then pick next cycle's ready.
	initial begin
		rot_rsp_t got;
		rot_rsp_t want;
		int hold_left;
		bit hold_done;
		rsp_ch.ready = 1'b0;
		hold_left    = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_z, rsp_ch.saturated};
				if (rotated_pending.size() == 0) begin
					$error("response with no request outstanding: r_x %0d r_y %0d r_z %0d",
						got.r_x, got.r_y, got.r_z);
					n_errors++;
				end else begin
					want = rotated_pending.pop_front();
					if (got.r_x !== want.r_x) begin
						$error("r_x: expected %0d, got %0d", want.r_x, got.r_x);
						n_errors++;
					end
					if (got.r_y !== want.r_y) begin
						$error("r_y: expected %0d, got %0d", want.r_y, got.r_y);
						n_errors++;
					end
					if (got.r_z !== want.r_z) begin
						$error("r_z: expected %0d, got %0d", want.r_z, got.r_z);
						n_errors++;
					end
					if (got.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							got.saturated);
						n_errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !takes_break();
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_MAX) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
